// File: rtl/rcw_pkg.sv
// Shared types and constants for the Reno congestion window block.
`default_nettype none

package rcw_pkg;

    // Field widths fixed by the interface.
    localparam int IDX_W  = 10;
    localparam int LOW_W  = 11;
    localparam int HIGH_W = 12;
    localparam int THR_W  = 11;
    localparam int CFG_W  = 11;

    // Default depth of the per-packet acknowledgement count store.
    localparam int MAX_PACKETS_DEF = 1024;

    // Two-bit acknowledgement count, saturating at three.
    typedef logic [1:0] t_count;
    localparam t_count CNT_MAX = 2'd3;

    // Operation codes of an input beat.
    localparam logic OP_ACK     = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_IDX_INIT_THR = 1'b0;
    localparam logic CFG_IDX_TOTAL    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0] INIT_THR_RST = 11'd15;
    localparam logic [LOW_W-1:0] TOTAL_RST    = 11'd1024;

    // Saturation limit of the window's high edge and the avoidance counter.
    localparam logic [HIGH_W-1:0] HIGH_MAX = 12'hFFF;

endpackage

`default_nettype wire

// File: rtl/rcw_count_mem.sv
// Per-packet acknowledgement count store with a clearing sweep after reset.
`default_nettype none

module rcw_count_mem #(
    parameter int DEPTH = rcw_pkg::MAX_PACKETS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic [1:0]                   o_rd_data,
    input  wire                          i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  wire  [1:0]                   i_wr_data,
    output logic                         o_busy
);
    import rcw_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_count          r_mem [DEPTH];
    t_count          r_rd_data;
    logic [AW-1:0]   r_clr_addr;
    logic            r_busy;

    // Clearing sweep: one entry per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Write port, shared by the sweep and the update path.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && !r_busy && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

`default_nettype wire

// File: rtl/reno_congestion_window.sv
// Reno congestion window: sender-side window tracking in packet units.
//
// Input channel (i_in_valid / o_in_stall) carries one event per beat: an
// acknowledgement of packet i_ack_index, or a retransmission timeout.
// Output channel (o_out_valid / i_out_stall) returns one result beat per
// event: the window edges, phase, threshold, fast-retransmit request and
// a transfer-done flag, all as they stand after the event.
// The accepting edge registers the event in the work stage, and the result
// register takes it when it retires; one event per cycle is sustained while
// the receiver does not stall. The count store is read in the accept cycle
// and written back when the event retires, with same-entry writes forwarded
// to the read, so back-to-back events on one packet are exact. After reset
// the count store is swept to zero; o_in_stall is high during the sweep.
// Configuration writes are taken at any time but are meant for an idle
// block; writing the initial threshold also loads the working threshold.
// When the receiver stalls, the result register holds its beat, the event
// in the work stage waits behind it, and o_in_stall rises in that cycle.
`default_nettype none

module reno_congestion_window #(
    parameter int MAX_PACKETS = rcw_pkg::MAX_PACKETS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Configuration port.
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_index,
    input  wire  [rcw_pkg::CFG_W-1:0]    i_cfg_data,
    // Input channel.
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_op,
    input  wire  [rcw_pkg::IDX_W-1:0]    i_ack_index,
    // Output channel.
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [rcw_pkg::LOW_W-1:0]    o_window_low,
    output logic [rcw_pkg::HIGH_W-1:0]   o_window_high,
    output logic [1:0]                   o_phase,
    output logic                         o_retransmit,
    output logic [rcw_pkg::LOW_W-1:0]    o_retransmit_index,
    output logic [rcw_pkg::THR_W-1:0]    o_threshold,
    output logic                         o_done_res
);
    import rcw_pkg::*;

    localparam int AW = $clog2(MAX_PACKETS);

    typedef enum logic [1:0] {
        PH_SLOW    = 2'd0,
        PH_AVOID   = 2'd1,
        PH_RECOVER = 2'd2
    } t_phase;

    // Clamp a grown sum to the high-edge range.
    function automatic logic [HIGH_W-1:0] sat_high(input logic [HIGH_W:0] v);
        return (v > {1'b0, HIGH_MAX}) ? HIGH_MAX : v[HIGH_W-1:0];
    endfunction

    // Window size, zero when the edges cross.
    function automatic logic [HIGH_W-1:0] win_span(input logic [HIGH_W-1:0] h,
                                                   input logic [LOW_W-1:0]  l);
        return (h >= HIGH_W'(l)) ? (h - HIGH_W'(l)) : '0;
    endfunction

    // Configuration register.
    logic [LOW_W-1:0]  r_total;

    // Window state.
    logic [LOW_W-1:0]  r_low,   n_low;
    logic [HIGH_W-1:0] r_high,  n_high;
    t_phase            r_phase, n_phase;
    logic [HIGH_W-1:0] r_avoid, n_avoid;
    logic [THR_W-1:0]  r_thr,   n_thr;
    logic [IDX_W-1:0]  r_rec,   n_rec;
    logic              n_rtx;
    logic [LOW_W-1:0]  n_rtx_idx;
    logic              n_done;

    // Work stage.
    logic              r_s1_valid;
    logic              r_s1_op;
    logic [IDX_W-1:0]  r_s1_idx;

    // Result register.
    logic              r_out_valid;
    logic [LOW_W-1:0]  r_out_low;
    logic [HIGH_W-1:0] r_out_high;
    t_phase            r_out_phase;
    logic              r_out_rtx;
    logic [LOW_W-1:0]  r_out_rtx_idx;
    logic [THR_W-1:0]  r_out_thr;
    logic              r_out_done;

    // Handshake and count store signals.
    logic              w_adv;
    logic              w_accept;
    logic              w_busy;
    t_count            w_cnt;
    logic              w_cnt_we;
    t_count            w_cnt_wdata;
    logic [LOW_W-1:0]  w_total;
    logic [LOW_W-1:0]  w_low1;
    logic [HIGH_W-1:0] w_high1;
    logic [HIGH_W-1:0] w_high2;
    logic [HIGH_W-1:0] w_avoid1;
    logic [LOW_W-1:0]  w_j;

    // The work stage retires when the result register is free or being taken.
    assign w_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = w_busy || (r_s1_valid && !w_adv);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Totals above the store depth act as the depth.
    always_comb begin
        if (32'(r_total) > MAX_PACKETS) begin
            w_total = LOW_W'(MAX_PACKETS);
        end else begin
            w_total = r_total;
        end
    end

    rcw_count_mem #(
        .DEPTH (MAX_PACKETS)
    ) u_count_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (AW'(i_ack_index)),
        .o_rd_data (w_cnt),
        .i_wr_en   (w_cnt_we),
        .i_wr_addr (AW'(r_s1_idx)),
        .i_wr_data (w_cnt_wdata),
        .o_busy    (w_busy)
    );

    // Next window state for the event in the work stage.
    always_comb begin
        n_low       = r_low;
        n_high      = r_high;
        n_phase     = r_phase;
        n_avoid     = r_avoid;
        n_thr       = r_thr;
        n_rec       = r_rec;
        n_rtx       = 1'b0;
        n_rtx_idx   = '0;
        w_cnt_we    = 1'b0;
        w_cnt_wdata = w_cnt + 2'd1;
        w_j         = {1'b0, r_s1_idx};
        w_low1      = r_low;
        w_high1     = r_high;
        w_high2     = sat_high({1'b0, r_high} + 13'd1);
        w_avoid1    = r_avoid;

        if (r_s1_valid && (r_low < w_total)) begin
            if (r_s1_op == OP_TIMEOUT) begin
                // Timeout: half the window becomes the threshold, window of one.
                n_thr   = THR_W'(win_span(r_high, r_low) >> 1);
                n_high  = HIGH_W'(r_low) + 12'd1;
                n_phase = PH_SLOW;
            end else if (w_j < w_total) begin
                // Slide the window on a new acknowledgement.
                if (w_j >= r_low) begin
                    w_high1 = sat_high({1'b0, r_high} + 13'(w_j) + 13'd1 - 13'(r_low));
                    w_low1  = w_j + 11'd1;
                end
                w_high2  = sat_high({1'b0, w_high1} + 13'd1);
                w_avoid1 = (r_avoid != HIGH_MAX) ? (r_avoid + 12'd1) : r_avoid;
                n_low    = w_low1;
                n_high   = w_high1;

                priority if ((w_j + 11'd1 == w_low1) && (w_cnt == CNT_MAX) &&
                             (r_phase != PH_RECOVER)) begin
                    // Third duplicate: enter fast recovery and retransmit.
                    n_phase   = PH_RECOVER;
                    n_rtx     = 1'b1;
                    n_rtx_idx = w_low1;
                    n_thr     = THR_W'(win_span(w_high1, w_low1) >> 1);
                    n_high    = sat_high(13'(w_low1) + 13'(n_thr) + 13'd3);
                    n_rec     = r_s1_idx;
                end else if ((r_phase == PH_SLOW) && (w_cnt == '0)) begin
                    n_high = w_high2;
                    if (win_span(w_high2, w_low1) > HIGH_W'(r_thr)) begin
                        n_phase = PH_AVOID;
                    end
                end else if ((r_phase == PH_AVOID) && (w_cnt == '0)) begin
                    // One packet per window's worth of new acknowledgements.
                    if (w_avoid1 >= win_span(w_high1, w_low1)) begin
                        n_avoid = '0;
                        n_high  = w_high2;
                    end else begin
                        n_avoid = w_avoid1;
                    end
                end else if (r_phase == PH_RECOVER) begin
                    if (r_s1_idx > r_rec) begin
                        n_phase = PH_AVOID;
                        n_high  = sat_high(13'(w_low1) + 13'(r_thr) + 13'd1);
                    end else begin
                        n_high = w_high2;
                    end
                end else begin
                    n_high = w_high1;
                end

                w_cnt_we = w_adv && (w_cnt != CNT_MAX);
            end
        end
        n_done = (n_low >= w_total);
    end

    // Pipeline, state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= TOTAL_RST;
            r_low       <= '0;
            r_high      <= 12'd1;
            r_phase     <= PH_SLOW;
            r_avoid     <= '0;
            r_thr       <= INIT_THR_RST;
            r_rec       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_s1_op    <= i_op;
                r_s1_idx   <= i_ack_index;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (w_adv) begin
                r_low         <= n_low;
                r_high        <= n_high;
                r_phase       <= n_phase;
                r_avoid       <= n_avoid;
                r_thr         <= n_thr;
                r_rec         <= n_rec;
                r_out_valid   <= 1'b1;
                r_out_low     <= n_low;
                r_out_high    <= n_high;
                r_out_phase   <= n_phase;
                r_out_rtx     <= n_rtx;
                r_out_rtx_idx <= n_rtx_idx;
                r_out_thr     <= n_thr;
                r_out_done    <= n_done;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IDX_INIT_THR: begin
                        r_thr <= i_cfg_data;
                    end
                    CFG_IDX_TOTAL: begin
                        r_total <= i_cfg_data;
                    end
                    default: begin
                        r_total <= r_total;
                    end
                endcase
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_window_low       = r_out_low;
    assign o_window_high      = r_out_high;
    assign o_phase            = r_out_phase;
    assign o_retransmit       = r_out_rtx;
    assign o_retransmit_index = r_out_rtx_idx;
    assign o_threshold        = r_out_thr;
    assign o_done_res         = r_out_done;

    // A retransmit request always comes with fast recovery.
    a_rtx_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rtx) |-> (r_out_phase == PH_RECOVER))
        else $error("retransmit outside fast recovery");

    // The retransmitted packet is the new low edge of the window.
    a_rtx_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rtx) |-> (r_out_rtx_idx == r_out_low))
        else $error("retransmit index differs from window low edge");

    // No event is taken while the count store is being swept.
    a_sweep_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_accept)
        else $error("event accepted during count store sweep");

    // An event that cannot retire stays in the work stage.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> r_s1_valid)
        else $error("work stage event lost while blocked");

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the Reno congestion window block.
`timescale 1ns / 1ps

module tb;
    import rcw_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int MAXP = MAX_PACKETS_DEF;
    // Fast recovery inflates the window by the three duplicates already seen.
    localparam int unsigned RECOVERY_INFLATE = 3;
    localparam int unsigned EXIT_INFLATE = 1;

    typedef enum logic [1:0] {
        PH_SLOW    = 2'd0,
        PH_AVOID   = 2'd1,
        PH_RECOVER = 2'd2
    } t_phase;

    typedef struct {
        logic              op;
        logic [IDX_W-1:0]  idx;
    } t_ack_event;

    typedef struct {
        logic [LOW_W-1:0]  low;
        logic [HIGH_W-1:0] high;
        t_phase            phase;
        logic              rtx;
        logic [LOW_W-1:0]  rtx_idx;
        logic [THR_W-1:0]  thr;
        logic              done;
    } t_window;

    // Clock, reset and block inputs, all known from time zero.
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = CFG_IDX_INIT_THR;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              i_op = OP_ACK;
    logic [IDX_W-1:0]  i_ack_index = '0;
    logic              i_out_stall = 1'b0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [LOW_W-1:0]  o_window_low;
    logic [HIGH_W-1:0] o_window_high;
    logic [1:0]        o_phase;
    logic              o_retransmit;
    logic [LOW_W-1:0]  o_retransmit_index;
    logic [THR_W-1:0]  o_threshold;
    logic              o_done_res;

    reno_congestion_window i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_ack_index        (i_ack_index),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_window_low       (o_window_low),
        .o_window_high      (o_window_high),
        .o_phase            (o_phase),
        .o_retransmit       (o_retransmit),
        .o_retransmit_index (o_retransmit_index),
        .o_threshold        (o_threshold),
        .o_done_res         (o_done_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predicted window state and the configuration it runs under.
    int unsigned cfg_total = TOTAL_RST;
    int unsigned cw_low = 0;
    int unsigned cw_high = 1;
    int unsigned cw_avoid = 0;
    int unsigned cw_thr = INIT_THR_RST;
    int unsigned cw_rec = 0;
    t_phase      cw_phase = PH_SLOW;
    t_count      ack_seen [MAXP];

    t_ack_event  ack_events[$];
    t_window     predicted_windows[$];
    int unsigned gen_low = 0;
    int          fault_count = 0;
    int          cycle_count = 0;
    int          send_wait = 0;
    int          recv_wait = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    initial begin
        foreach (ack_seen[k]) ack_seen[k] = '0;
    end

    function automatic int unsigned cap_total(int unsigned t);
        return (t > MAXP) ? MAXP : t;
    endfunction

    function automatic int unsigned sat_edge(int unsigned v);
        return (v > HIGH_MAX) ? HIGH_MAX : v;
    endfunction

    function automatic int unsigned win_span();
        return (cw_high >= cw_low) ? cw_high - cw_low : 0;
    endfunction

    // Apply one event to the predicted state and return the beat it yields.
    function automatic t_window advance_window(logic op, logic [IDX_W-1:0] idx);
        int unsigned tot;
        int unsigned j;
        int unsigned cnt;
        bit          fin;
        t_window     r;
        tot = cap_total(cfg_total);
        j = 32'(idx);
        fin = cw_low >= tot;
        r.rtx = 1'b0;
        r.rtx_idx = '0;
        if (!fin && op == OP_TIMEOUT) begin
            cw_thr = (win_span() / 2) & 32'h7FF;
            cw_high = sat_edge(cw_low + 1);
            cw_phase = PH_SLOW;
        end else if (!fin && op == OP_ACK && j < tot) begin
            if (j >= cw_low) begin
                cw_high = sat_edge(cw_high + (j + 1 - cw_low));
                cw_low = j + 1;
            end
            cnt = 32'(ack_seen[j]);
            if (j + 1 == cw_low && cnt >= CNT_MAX && cw_phase != PH_RECOVER) begin
                // Third duplicate: halve, inflate and ask for the next packet.
                cw_phase = PH_RECOVER;
                r.rtx = 1'b1;
                r.rtx_idx = LOW_W'(j + 1);
                cw_thr = (win_span() / 2) & 32'h7FF;
                cw_high = sat_edge(cw_low + cw_thr + RECOVERY_INFLATE);
                cw_rec = j;
            end else if (cw_phase == PH_SLOW && cnt == 0) begin
                cw_high = sat_edge(cw_high + 1);
                if (win_span() > cw_thr) cw_phase = PH_AVOID;
            end else if (cw_phase == PH_AVOID && cnt == 0) begin
                if (cw_avoid < HIGH_MAX) cw_avoid++;
                if (cw_avoid >= win_span()) begin
                    cw_avoid = 0;
                    cw_high = sat_edge(cw_high + 1);
                end
            end else if (cw_phase == PH_RECOVER) begin
                if (j > cw_rec) begin
                    cw_phase = PH_AVOID;
                    cw_high = sat_edge(cw_low + cw_thr + EXIT_INFLATE);
                end else begin
                    cw_high = sat_edge(cw_high + 1);
                end
            end
            if (cnt < CNT_MAX) ack_seen[j] = t_count'(cnt + 1);
        end
        r.low = LOW_W'(cw_low);
        r.high = HIGH_W'(cw_high);
        r.phase = cw_phase;
        r.thr = THR_W'(cw_thr);
        r.done = cw_low >= tot;
        return r;
    endfunction

    function automatic string fmt_window(t_window w);
        return $sformatf("low %0d high %0d phase %0d rtx %0d/%0d thr %0d done %0d",
                         w.low, w.high, w.phase, w.rtx, w.rtx_idx, w.thr, w.done);
    endfunction

    // Per-beat wait, with occasional runs of back-to-back beats.
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 39) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic log_fault(string what);
        fault_count++;
        if (fault_count <= 10) $display("tb: mismatch: %s", what);
    endtask

    // Input driver: presents queued events, waiting a drawn gap before each.
    always @(posedge i_clk) begin : drive_events
        logic       nv;
        t_ack_event ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nv = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predicted_windows.push_back(advance_window(i_op, i_ack_index));
                nv = 1'b0;
                send_wait = draw_wait(send_burst);
            end
            if (!nv) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (ack_events.size() > 0) begin
                    ev = ack_events.pop_front();
                    i_op <= ev.op;
                    i_ack_index <= ev.idx;
                    nv = 1'b1;
                end
            end
            i_in_valid <= nv;
        end
    end

    // Result monitor: stalls at random and checks each beat in order.
    always @(posedge i_clk) begin : check_results
        t_window want;
        t_window got;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.low = o_window_low;
                got.high = o_window_high;
                got.phase = t_phase'(o_phase);
                got.rtx = o_retransmit;
                got.rtx_idx = o_retransmit_index;
                got.thr = o_threshold;
                got.done = o_done_res;
                if (predicted_windows.size() == 0) begin
                    log_fault({"unexpected beat: ", fmt_window(got)});
                end else begin
                    want = predicted_windows.pop_front();
                    if (o_window_low !== want.low || o_window_high !== want.high ||
                        o_phase !== want.phase || o_retransmit !== want.rtx ||
                        o_retransmit_index !== want.rtx_idx ||
                        o_threshold !== want.thr || o_done_res !== want.done)
                        log_fault({"expected ", fmt_window(want),
                                   " got ", fmt_window(got)});
                end
                recv_wait = draw_wait(recv_burst);
            end else if (o_out_valid && recv_wait > 0) begin
                recv_wait--;
            end
            i_out_stall <= (recv_wait != 0);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_IDX_INIT_THR) cw_thr = 32'(val);
        else cfg_total = 32'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every queued event is answered, then let the pipeline drain.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (ack_events.size() != 0 || i_in_valid || predicted_windows.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Queue one event and track where the low edge will stand.
    task automatic queue_event(logic op, int unsigned idx);
        t_ack_event ev;
        int unsigned tot;
        ev.op = op;
        ev.idx = IDX_W'(idx);
        ack_events.push_back(ev);
        tot = cap_total(cfg_total);
        if (gen_low < tot && op == OP_ACK && idx < tot && idx >= gen_low) gen_low = idx + 1;
    endtask

    // Mostly in-order and duplicate acknowledgements, with timeouts and noise.
    task automatic fill_phase(int n);
        int          counted;
        int          made;
        int unsigned r;
        int unsigned j;
        int unsigned tot;
        int          dups;
        counted = 0;
        made = 0;
        while (counted < n && made < n + 20) begin
            tot = cap_total(cfg_total);
            if (gen_low < tot) counted++;
            made++;
            r = $urandom_range(0, 99);
            if (r < 45) begin
                j = gen_low + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
                queue_event(OP_ACK, (j > 1023) ? 1023 : j);
            end else if (r < 65 && gen_low > 0) begin
                dups = $urandom_range(2, 6);
                repeat (dups) queue_event(OP_ACK, gen_low - 1);
            end else if (r < 73) begin
                queue_event(OP_TIMEOUT, $urandom_range(0, 1023));
            end else if (r < 88) begin
                queue_event(OP_ACK, (gen_low > 0) ? $urandom_range(0, gen_low - 1) : 0);
            end else begin
                queue_event(OP_ACK, $urandom_range(0, 1023));
            end
        end
    endtask

    initial begin : stimulus
        int unsigned base;
        int unsigned tot_next;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: recovery entry and exit, double timeout, out of range, done.
        write_reg(CFG_IDX_INIT_THR, 11'd1);
        write_reg(CFG_IDX_TOTAL, 11'd12);
        repeat (5) queue_event(OP_ACK, 0);
        queue_event(OP_ACK, 2);
        queue_event(OP_ACK, 3);
        queue_event(OP_ACK, 4);
        queue_event(OP_TIMEOUT, 1023);
        queue_event(OP_TIMEOUT, 0);
        queue_event(OP_ACK, 5);
        queue_event(OP_ACK, 1023);
        queue_event(OP_ACK, 7);
        queue_event(OP_ACK, 6);
        queue_event(OP_ACK, 11);
        queue_event(OP_ACK, 3);
        queue_event(OP_TIMEOUT, 512);
        wait_idle();

        // Random phases, each under its own settings.
        for (int p = 0; p < 8; p++) begin
            base = gen_low + $urandom_range(40, 90);
            tot_next = (base > MAXP) ? MAXP : base;
            case (p)
                0: begin
                    write_reg(CFG_IDX_INIT_THR, 11'd2047);
                    write_reg(CFG_IDX_TOTAL, CFG_W'(tot_next));
                end
                1: begin
                    write_reg(CFG_IDX_INIT_THR, 11'd0);
                    write_reg(CFG_IDX_TOTAL, CFG_W'(tot_next));
                end
                2: begin
                    write_reg(CFG_IDX_INIT_THR, CFG_W'($urandom_range(1, 40)));
                    write_reg(CFG_IDX_TOTAL, CFG_W'(tot_next));
                end
                3: begin
                    // A zero total leaves every event without effect.
                    write_reg(CFG_IDX_INIT_THR, CFG_W'($urandom_range(1, 40)));
                    write_reg(CFG_IDX_TOTAL, 11'd0);
                end
                4: begin
                    write_reg(CFG_IDX_INIT_THR, INIT_THR_RST);
                    write_reg(CFG_IDX_TOTAL, CFG_W'(tot_next));
                end
                5: begin
                    write_reg(CFG_IDX_INIT_THR, CFG_W'($urandom_range(1, 100)));
                    write_reg(CFG_IDX_TOTAL,
                              CFG_W'(((gen_low + 100) > MAXP) ? MAXP : gen_low + 100));
                end
                6: begin
                    write_reg(CFG_IDX_INIT_THR, 11'd1);
                    write_reg(CFG_IDX_TOTAL, TOTAL_RST);
                end
                default: begin
                    write_reg(CFG_IDX_INIT_THR, CFG_W'($urandom_range(1, 2047)));
                    write_reg(CFG_IDX_TOTAL, 11'd2047);
                end
            endcase
            if (p == 3) begin
                fill_phase(0);
            end else if (p == 5) begin
                // A long duplicate stream keeps recovery open and inflates
                // the window one packet per beat.
                repeat (60) queue_event(OP_ACK, gen_low - 1);
                fill_phase(30);
            end else begin
                fill_phase(50);
            end
            if (p == 7) begin
                queue_event(OP_ACK, 1023);
                queue_event(OP_TIMEOUT, 0);
                queue_event(OP_ACK, 1023);
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (fault_count == 0 && predicted_windows.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
